>>> rtl/mbrtu_pkg.sv
// Package for the Modbus RTU master frame engine.
// Holds the item and result payload types, code constants and the CRC-16 byte update.
// No dependencies.
package mbrtu_pkg;

	localparam int unsigned MAX_REGISTERS = 125;

	// Configuration register indexes.
	localparam logic [2:0] CFG_SLAVE_ADDRESS    = 3'd0;
	localparam logic [2:0] CFG_FUNCTION_SELECT  = 3'd1;
	localparam logic [2:0] CFG_REGISTER_ADDRESS = 3'd2;
	localparam logic [2:0] CFG_REGISTER_COUNT   = 3'd3;
	localparam logic [2:0] CFG_WRITE_VALUE      = 3'd4;

	// Input item modes.
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_BYTE  = 1'b1;

	// Result kinds.
	localparam logic [1:0] KIND_REQUEST = 2'd0;
	localparam logic [1:0] KIND_WORD    = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;

	// Final status codes.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_ADDRESS    = 3'd1;
	localparam logic [2:0] ST_FUNCTION   = 3'd2;
	localparam logic [2:0] ST_BYTE_COUNT = 3'd3;
	localparam logic [2:0] ST_ECHO_ADDR  = 3'd4;
	localparam logic [2:0] ST_ECHO_VALUE = 3'd5;
	localparam logic [2:0] ST_CRC        = 3'd6;

	// Modbus function codes.
	localparam logic [7:0] FC_READ_HOLDING = 8'h03;
	localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] payload;
		logic [2:0]  status;
		logic        last;
	} result_t;

	typedef enum logic [10:0] {
		PH_IDLE   = 11'b000_0000_0001,
		PH_ADDR   = 11'b000_0000_0010,
		PH_FUNC   = 11'b000_0000_0100,
		PH_BCOUNT = 11'b000_0000_1000,
		PH_DATA   = 11'b000_0001_0000,
		PH_WAH    = 11'b000_0010_0000,
		PH_WAL    = 11'b000_0100_0000,
		PH_WVH    = 11'b000_1000_0000,
		PH_WVL    = 11'b001_0000_0000,
		PH_CRCL   = 11'b010_0000_0000,
		PH_CRCH   = 11'b100_0000_0000
	} phase_t;

	// CRC-16/MODBUS update by one byte, reflected, bit at a time.
	function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/modbus_rtu_master_frame_engine.sv
// Modbus RTU master frame engine: request builder, response checker and result register.
// Depends on mbrtu_pkg for payload types, codes and the CRC-16 update.
//
//  Channel   Signals                               Direction  Moves
//  item      item_valid, item_stall, item          in         start or one received byte
//  result    result_valid, result_stall, result    out        request byte, word or status
//  config    cfg_wr_en, cfg_index, cfg_data        in         register write, no read-back
//
// A start stays in the input stage until all eight request bytes have gone out, since
// the request is built and its CRC advanced one byte per cycle while the result
// register is free. An overflowing register count gives a single status.
// The input stage is held while its result cannot enter the result register; results then
// wait there under result_stall while the next item is already taken into the input stage.
// Reset empties both stages and returns the receive side to idle.
module modbus_rtu_master_frame_engine (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [2:0]              cfg_index,
	input  logic [15:0]             cfg_data,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  mbrtu_pkg::item_t        item,
	output logic                    result_valid,
	input  logic                    result_stall,
	output mbrtu_pkg::result_t      result
);

	// Configuration registers.
	logic [7:0]  slave_address_q;
	logic        function_select_q;
	logic [15:0] register_address_q;
	logic [6:0]  register_count_q;
	logic [15:0] write_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q    <= 8'd1;
			function_select_q  <= 1'b0;
			register_address_q <= 16'd0;
			register_count_q   <= 7'd1;
			write_value_q      <= 16'd0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mbrtu_pkg::CFG_SLAVE_ADDRESS:    slave_address_q    <= cfg_data[7:0];
				mbrtu_pkg::CFG_FUNCTION_SELECT:  function_select_q  <= cfg_data[0];
				mbrtu_pkg::CFG_REGISTER_ADDRESS: register_address_q <= cfg_data;
				mbrtu_pkg::CFG_REGISTER_COUNT:   register_count_q   <= cfg_data[6:0];
				mbrtu_pkg::CFG_WRITE_VALUE:      write_value_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage.
	logic              s1_valid_q;
	mbrtu_pkg::item_t  s1_q;
	logic              s1_done;
	logic              s1_take;

	// Result register.
	logic                result_valid_q;
	mbrtu_pkg::result_t  result_q;
	logic                out_free;

	// Request emitter.
	logic [2:0]  req_idx_q;
	logic [15:0] req_crc_q;

	// Receive state.
	mbrtu_pkg::phase_t phase_q, phase_d;
	logic [7:0]  byte_pos_q, byte_pos_d;
	logic [15:0] run_crc_q, run_crc_d;
	logic [7:0]  held_q, held_d;

	logic               res_has;
	mbrtu_pkg::result_t res;

	logic        is_start;
	logic        count_over;
	logic [7:0]  func_code;
	logic [15:0] req_word;
	logic [7:0]  req_byte;
	logic [7:0]  rx;
	logic [15:0] rx_crc_next;
	logic [7:0]  count_x2;
	logic [7:0]  pos_inc;
	logic [15:0] rx_pair;

	assign out_free   = !result_valid_q || !result_stall;
	assign is_start   = (s1_q.mode == mbrtu_pkg::MODE_START);
	assign count_over = !function_select_q &&
		({25'd0, register_count_q} > 32'(mbrtu_pkg::MAX_REGISTERS));
	assign func_code  = function_select_q ? mbrtu_pkg::FC_WRITE_SINGLE
		: mbrtu_pkg::FC_READ_HOLDING;
	assign req_word   = function_select_q ? write_value_q : {9'd0, register_count_q};
	assign rx         = s1_q.rx_byte;
	assign rx_crc_next = mbrtu_pkg::crc_update(run_crc_q, rx);
	assign count_x2   = {register_count_q, 1'b0};
	assign pos_inc    = byte_pos_q + 8'd1;
	assign rx_pair    = {held_q, rx};

	always_comb begin
		case (req_idx_q)
			3'd0:    req_byte = slave_address_q;
			3'd1:    req_byte = func_code;
			3'd2:    req_byte = register_address_q[15:8];
			3'd3:    req_byte = register_address_q[7:0];
			3'd4:    req_byte = req_word[15:8];
			3'd5:    req_byte = req_word[7:0];
			3'd6:    req_byte = req_crc_q[7:0];
			default: req_byte = req_crc_q[15:8];
		endcase
	end

	// Result and next receive state for the item held in the input stage.
	always_comb begin
		res_has    = 1'b0;
		res        = '0;
		phase_d    = phase_q;
		byte_pos_d = byte_pos_q;
		run_crc_d  = run_crc_q;
		held_d     = held_q;
		if (is_start) begin
			res_has = 1'b1;
			if (count_over) begin
				res.kind   = mbrtu_pkg::KIND_STATUS;
				res.status = mbrtu_pkg::ST_BYTE_COUNT;
				res.last   = 1'b1;
				phase_d    = mbrtu_pkg::PH_IDLE;
			end else begin
				res.kind    = mbrtu_pkg::KIND_REQUEST;
				res.payload = {8'd0, req_byte};
				res.last    = (req_idx_q == 3'd7);
				phase_d     = mbrtu_pkg::PH_ADDR;
				byte_pos_d  = 8'd0;
				run_crc_d   = mbrtu_pkg::CRC_INIT;
				held_d      = 8'd0;
			end
		end else begin
			res.kind = mbrtu_pkg::KIND_STATUS;
			res.last = 1'b1;
			case (phase_q)
				mbrtu_pkg::PH_IDLE: ;
				mbrtu_pkg::PH_CRCL: begin
					held_d  = rx;
					phase_d = mbrtu_pkg::PH_CRCH;
				end
				mbrtu_pkg::PH_CRCH: begin
					// The received CRC comes low byte first.
					res_has    = 1'b1;
					res.status = ({rx, held_q} == run_crc_q) ? mbrtu_pkg::ST_OK
						: mbrtu_pkg::ST_CRC;
					phase_d    = mbrtu_pkg::PH_IDLE;
				end
				mbrtu_pkg::PH_ADDR: begin
					run_crc_d = rx_crc_next;
					if (rx != slave_address_q) begin
						res_has    = 1'b1;
						res.status = mbrtu_pkg::ST_ADDRESS;
						phase_d    = mbrtu_pkg::PH_IDLE;
					end else begin
						phase_d = mbrtu_pkg::PH_FUNC;
					end
				end
				mbrtu_pkg::PH_FUNC: begin
					run_crc_d = rx_crc_next;
					if (rx != func_code) begin
						res_has    = 1'b1;
						res.status = mbrtu_pkg::ST_FUNCTION;
						phase_d    = mbrtu_pkg::PH_IDLE;
					end else begin
						phase_d = function_select_q ? mbrtu_pkg::PH_WAH : mbrtu_pkg::PH_BCOUNT;
					end
				end
				mbrtu_pkg::PH_BCOUNT: begin
					run_crc_d = rx_crc_next;
					if (rx != count_x2) begin
						res_has    = 1'b1;
						res.status = mbrtu_pkg::ST_BYTE_COUNT;
						phase_d    = mbrtu_pkg::PH_IDLE;
					end else begin
						byte_pos_d = 8'd0;
						phase_d    = (rx == 8'd0) ? mbrtu_pkg::PH_CRCL : mbrtu_pkg::PH_DATA;
					end
				end
				mbrtu_pkg::PH_DATA: begin
					run_crc_d  = rx_crc_next;
					byte_pos_d = pos_inc;
					if (pos_inc[0]) begin
						held_d = rx;
					end else begin
						res_has     = 1'b1;
						res.kind    = mbrtu_pkg::KIND_WORD;
						res.payload = rx_pair;
						res.last    = 1'b0;
						if (pos_inc >= count_x2) begin
							phase_d = mbrtu_pkg::PH_CRCL;
						end
					end
				end
				mbrtu_pkg::PH_WAH: begin
					run_crc_d = rx_crc_next;
					held_d    = rx;
					phase_d   = mbrtu_pkg::PH_WAL;
				end
				mbrtu_pkg::PH_WAL: begin
					run_crc_d = rx_crc_next;
					if (rx_pair != register_address_q) begin
						res_has    = 1'b1;
						res.status = mbrtu_pkg::ST_ECHO_ADDR;
						phase_d    = mbrtu_pkg::PH_IDLE;
					end else begin
						phase_d = mbrtu_pkg::PH_WVH;
					end
				end
				mbrtu_pkg::PH_WVH: begin
					run_crc_d = rx_crc_next;
					held_d    = rx;
					phase_d   = mbrtu_pkg::PH_WVL;
				end
				mbrtu_pkg::PH_WVL: begin
					run_crc_d = rx_crc_next;
					if (rx_pair != write_value_q) begin
						res_has    = 1'b1;
						res.status = mbrtu_pkg::ST_ECHO_VALUE;
						phase_d    = mbrtu_pkg::PH_IDLE;
					end else begin
						phase_d = mbrtu_pkg::PH_CRCL;
					end
				end
				default: phase_d = mbrtu_pkg::PH_IDLE;
			endcase
		end
	end

	// A start leaves the input stage with its eighth request byte, or with its status on an
	// overflowing count; other items with their single result, or at once when they give none.
	always_comb begin
		if (is_start) begin
			s1_done = out_free && (count_over || (req_idx_q == 3'd7));
		end else begin
			s1_done = !res_has || out_free;
		end
	end

	assign s1_take    = s1_valid_q && s1_done;
	assign item_stall = s1_valid_q && !s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!item_stall) begin
			s1_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			s1_q <= item;
		end
	end

	// The request CRC runs over the first six bytes as they go out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_idx_q <= 3'd0;
			req_crc_q <= mbrtu_pkg::CRC_INIT;
		end else if (s1_valid_q && is_start && !count_over && out_free) begin
			req_idx_q <= req_idx_q + 3'd1;
			if (req_idx_q == 3'd7) begin
				req_crc_q <= mbrtu_pkg::CRC_INIT;
			end else if (req_idx_q < 3'd6) begin
				req_crc_q <= mbrtu_pkg::crc_update(req_crc_q, req_byte);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= mbrtu_pkg::PH_IDLE;
			byte_pos_q <= 8'd0;
			run_crc_q  <= mbrtu_pkg::CRC_INIT;
			held_q     <= 8'd0;
		end else if (s1_take) begin
			phase_q    <= phase_d;
			byte_pos_q <= byte_pos_d;
			run_crc_q  <= run_crc_d;
			held_q     <= held_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= s1_valid_q && res_has;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_valid_q && res_has) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// The request counter only moves while a start sits in the input stage.
	a_req_idx_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req_idx_q != 3'd0) |-> (s1_valid_q && s1_q.mode == mbrtu_pkg::MODE_START))
		else $error("request byte counter running without a start item");

	// A byte arriving while idle never produces a result.
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && s1_q.mode == mbrtu_pkg::MODE_BYTE && phase_q == mbrtu_pkg::PH_IDLE)
		|-> !res_has)
		else $error("result produced for a byte while idle");

	// Register words come only from the data phase.
	a_word_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && res_has && res.kind == mbrtu_pkg::KIND_WORD)
		|-> (phase_q == mbrtu_pkg::PH_DATA))
		else $error("register word outside the data phase");

	// A result loaded into the result register appears valid on the next cycle.
	a_load_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && res_has && out_free) |=> result_valid)
		else $error("loaded result not presented");
`endif

endmodule

>>> tb/modbus_rtu_master_frame_engine_tb.sv
// Self-checking testbench for the Modbus RTU master frame engine.
// It drives requests and line bytes and checks request bytes, register words and status.
// Depends on mbrtu_pkg and on rtl/modbus_rtu_master_frame_engine.sv.
module modbus_rtu_master_frame_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Ways a random response frame is damaged.
	localparam int FLAW_NONE = 0;
	localparam int FLAW_FLIP = 1;
	localparam int FLAW_CUT  = 2;
	localparam int FLAW_TAIL = 3;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 12;
	localparam int RANDOM_ITEMS   = 280;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               item_valid;
	logic               item_stall;
	mbrtu_pkg::item_t   item;
	logic               result_valid;
	logic               result_stall;
	mbrtu_pkg::result_t result;

	// Mirror of the configuration registers.
	logic [7:0]  m_slave;
	logic        m_fsel;
	logic [15:0] m_raddr;
	logic [6:0]  m_rcount;
	logic [15:0] m_wvalue;

	// Mirror of the receive side.
	mbrtu_pkg::phase_t rx_phase;
	logic [7:0]  rx_pos;
	logic [15:0] rx_crc;
	logic [7:0]  rx_held;

	mbrtu_pkg::result_t engine_out_q [$];
	bit          quiet_gaps;
	int          errors;
	int          items_sent;
	int          results_checked;
	int          transactions;
	int          settings_applied;
	int          idle_cycles;
	logic [6:0]  seen_status;

	modbus_rtu_master_frame_engine DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] acc;
		acc = {crc[15:8], crc[7:0] ^ b};
		repeat (8) begin
			acc = acc[0] ? ({1'b0, acc[15:1]} ^ mbrtu_pkg::CRC_POLY) : {1'b0, acc[15:1]};
		end
		return acc;
	endfunction

	function automatic void push_out(input logic [1:0] k, input logic [15:0] p,
			input logic [2:0] s, input logic l);
		mbrtu_pkg::result_t r;
		r.kind = k;
		r.payload = p;
		r.status = s;
		r.last = l;
		engine_out_q.push_back(r);
	endfunction

	function automatic void close_frame(input logic [2:0] code);
		push_out(mbrtu_pkg::KIND_STATUS, 16'h0000, code, 1'b1);
		seen_status[code] = 1'b1;
		rx_phase = mbrtu_pkg::PH_IDLE;
	endfunction

	// Works out what one accepted item makes the engine emit.
	function automatic void track_item(input mbrtu_pkg::item_t it);
		logic [7:0]  req [8];
		logic [15:0] c;
		logic [15:0] word;
		logic [7:0]  fc;
		logic [7:0]  b;
		b = it.rx_byte;
		fc = m_fsel ? mbrtu_pkg::FC_WRITE_SINGLE : mbrtu_pkg::FC_READ_HOLDING;
		if (it.mode == mbrtu_pkg::MODE_START) begin
			if (!m_fsel && m_rcount > mbrtu_pkg::MAX_REGISTERS) begin
				close_frame(mbrtu_pkg::ST_BYTE_COUNT);
				return;
			end
			word = m_fsel ? m_wvalue : {9'd0, m_rcount};
			req[0] = m_slave;
			req[1] = fc;
			req[2] = m_raddr[15:8];
			req[3] = m_raddr[7:0];
			req[4] = word[15:8];
			req[5] = word[7:0];
			c = mbrtu_pkg::CRC_INIT;
			for (int i = 0; i < 6; i++) c = crc16_byte(c, req[i]);
			req[6] = c[7:0];
			req[7] = c[15:8];
			for (int i = 0; i < 8; i++) begin
				push_out(mbrtu_pkg::KIND_REQUEST, {8'h00, req[i]}, mbrtu_pkg::ST_OK, i == 7);
			end
			rx_phase = mbrtu_pkg::PH_ADDR;
			rx_pos = 8'd0;
			rx_crc = mbrtu_pkg::CRC_INIT;
			rx_held = 8'd0;
			return;
		end
		case (rx_phase)
			mbrtu_pkg::PH_IDLE: begin
			end
			mbrtu_pkg::PH_CRCL: begin
				rx_held = b;
				rx_phase = mbrtu_pkg::PH_CRCH;
			end
			mbrtu_pkg::PH_CRCH: begin
				close_frame(({b, rx_held} == rx_crc) ? mbrtu_pkg::ST_OK : mbrtu_pkg::ST_CRC);
			end
			default: begin
				rx_crc = crc16_byte(rx_crc, b);
				case (rx_phase)
					mbrtu_pkg::PH_ADDR: begin
						if (b != m_slave) close_frame(mbrtu_pkg::ST_ADDRESS);
						else rx_phase = mbrtu_pkg::PH_FUNC;
					end
					mbrtu_pkg::PH_FUNC: begin
						if (b != fc) close_frame(mbrtu_pkg::ST_FUNCTION);
						else rx_phase = m_fsel ? mbrtu_pkg::PH_WAH : mbrtu_pkg::PH_BCOUNT;
					end
					mbrtu_pkg::PH_BCOUNT: begin
						if (b != {m_rcount, 1'b0}) begin
							close_frame(mbrtu_pkg::ST_BYTE_COUNT);
						end else begin
							rx_pos = 8'd0;
							rx_phase = (b == 8'd0) ? mbrtu_pkg::PH_CRCL : mbrtu_pkg::PH_DATA;
						end
					end
					mbrtu_pkg::PH_DATA: begin
						rx_pos = rx_pos + 8'd1;
						if (rx_pos[0]) begin
							rx_held = b;
						end else begin
							push_out(mbrtu_pkg::KIND_WORD, {rx_held, b}, mbrtu_pkg::ST_OK, 1'b0);
							if (rx_pos >= {m_rcount, 1'b0}) rx_phase = mbrtu_pkg::PH_CRCL;
						end
					end
					mbrtu_pkg::PH_WAH, mbrtu_pkg::PH_WVH: begin
						rx_held = b;
						rx_phase = (rx_phase == mbrtu_pkg::PH_WAH) ? mbrtu_pkg::PH_WAL
							: mbrtu_pkg::PH_WVL;
					end
					mbrtu_pkg::PH_WAL: begin
						if ({rx_held, b} != m_raddr) close_frame(mbrtu_pkg::ST_ECHO_ADDR);
						else rx_phase = mbrtu_pkg::PH_WVH;
					end
					mbrtu_pkg::PH_WVL: begin
						if ({rx_held, b} != m_wvalue) close_frame(mbrtu_pkg::ST_ECHO_VALUE);
						else rx_phase = mbrtu_pkg::PH_CRCL;
					end
					default: rx_phase = mbrtu_pkg::PH_IDLE;
				endcase
			end
		endcase
	endfunction

	task automatic send_item(input logic md, input logic [7:0] b);
		mbrtu_pkg::item_t it;
		int gap;
		it.mode = md;
		it.rx_byte = b;
		gap = quiet_gaps ? 0 : $urandom_range(0, 16);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		track_item(it);
		items_sent++;
		if (md == mbrtu_pkg::MODE_START) transactions++;
	endtask

	// Lets every outstanding result drain and the engine go quiet.
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (engine_out_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [7:0] sa, input logic fs, input logic [15:0] ra,
			input logic [6:0] rc, input logic [15:0] wv);
		logic [2:0]  idx [5];
		logic [15:0] val [5];
		idx = '{mbrtu_pkg::CFG_SLAVE_ADDRESS, mbrtu_pkg::CFG_FUNCTION_SELECT,
			mbrtu_pkg::CFG_REGISTER_ADDRESS, mbrtu_pkg::CFG_REGISTER_COUNT,
			mbrtu_pkg::CFG_WRITE_VALUE};
		val = '{{8'h00, sa}, {15'h0000, fs}, ra, {9'h000, rc}, wv};
		settle();
		for (int i = 0; i < 5; i++) begin
			@(negedge clk);
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			case (idx[i])
				mbrtu_pkg::CFG_SLAVE_ADDRESS:    m_slave = val[i][7:0];
				mbrtu_pkg::CFG_FUNCTION_SELECT:  m_fsel = val[i][0];
				mbrtu_pkg::CFG_REGISTER_ADDRESS: m_raddr = val[i];
				mbrtu_pkg::CFG_REGISTER_COUNT:   m_rcount = val[i][6:0];
				default:                         m_wvalue = val[i];
			endcase
		end
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		settings_applied++;
	endtask

	// Sends the slave's answer to the current request, possibly damaged.
	task automatic send_response(input int flaw);
		logic [7:0]  fr [$];
		logic [15:0] c;
		int          pos;
		int          cut;
		if (!m_fsel && m_rcount > mbrtu_pkg::MAX_REGISTERS) return;
		fr.push_back(m_slave);
		fr.push_back(m_fsel ? mbrtu_pkg::FC_WRITE_SINGLE : mbrtu_pkg::FC_READ_HOLDING);
		if (m_fsel) begin
			fr.push_back(m_raddr[15:8]);
			fr.push_back(m_raddr[7:0]);
			fr.push_back(m_wvalue[15:8]);
			fr.push_back(m_wvalue[7:0]);
		end else begin
			fr.push_back({m_rcount, 1'b0});
			for (int i = 0; i < 2 * m_rcount; i++) fr.push_back(8'($urandom_range(0, 255)));
		end
		c = mbrtu_pkg::CRC_INIT;
		foreach (fr[i]) c = crc16_byte(c, fr[i]);
		fr.push_back(c[7:0]);
		fr.push_back(c[15:8]);
		// Long reads are broken off early so that most traffic stays short.
		if (!m_fsel && m_rcount > 6) begin
			cut = $urandom_range(3, 15);
			while (fr.size() > cut) void'(fr.pop_back());
		end
		case (flaw)
			FLAW_FLIP: begin
				pos = $urandom_range(0, fr.size() - 1);
				fr[pos] = fr[pos] ^ 8'($urandom_range(1, 255));
			end
			FLAW_CUT: begin
				cut = $urandom_range(1, fr.size() - 1);
				while (fr.size() > cut) void'(fr.pop_back());
			end
			FLAW_TAIL: begin
				repeat ($urandom_range(1, 3)) fr.push_back(8'($urandom_range(0, 255)));
			end
			default: begin
			end
		endcase
		foreach (fr[i]) send_item(mbrtu_pkg::MODE_BYTE, fr[i]);
	endtask

	task automatic test_reset_defaults();
		// A byte before any start must be dropped.
		send_item(mbrtu_pkg::MODE_BYTE, 8'h55);
		send_item(mbrtu_pkg::MODE_START, 8'hFF);
		send_response(FLAW_NONE);
	endtask

	task automatic test_count_limits();
		apply_settings(8'hFF, 1'b0, 16'hFFFF, 7'd127, 16'hFFFF);
		send_item(mbrtu_pkg::MODE_START, 8'h00);
		apply_settings(8'hFF, 1'b0, 16'hFFFF, 7'd126, 16'hFFFF);
		send_item(mbrtu_pkg::MODE_START, 8'h00);
		apply_settings(8'hFF, 1'b0, 16'hFFFF, 7'd125, 16'hFFFF);
		send_item(mbrtu_pkg::MODE_START, 8'h00);
		send_item(mbrtu_pkg::MODE_BYTE, 8'hFF);
		// The next start drops the read that is still open.
		apply_settings(8'h00, 1'b0, 16'h0000, 7'd0, 16'h0000);
		send_item(mbrtu_pkg::MODE_START, 8'h00);
		send_response(FLAW_NONE);
		send_item(mbrtu_pkg::MODE_BYTE, 8'hAA);
	endtask

	task automatic test_write_echo();
		apply_settings(8'h5A, 1'b1, 16'hFFFF, 7'd0, 16'h0000);
		send_item(mbrtu_pkg::MODE_START, 8'h80);
		send_response(FLAW_NONE);
	endtask

	task automatic test_random_traffic();
		int first;
		int pick;
		int flaw;
		logic [7:0]  sa;
		logic [15:0] ra;
		logic [15:0] wv;
		logic [6:0]  rc;
		first = items_sent;
		while (items_sent - first < RANDOM_ITEMS) begin
			if (items_sent == first || $urandom_range(0, 2) == 0) begin
				quiet_gaps = ($urandom_range(0, 3) == 0);
				sa = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
					: 8'($urandom_range(0, 255));
				ra = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
					: 16'($urandom_range(0, 65535));
				wv = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
					: 16'($urandom_range(0, 65535));
				rc = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
					: 7'($urandom_range(0, 6));
				apply_settings(sa, 1'($urandom_range(0, 1)), ra, rc, wv);
			end
			if ($urandom_range(0, 4) == 0) begin
				send_item(mbrtu_pkg::MODE_BYTE, 8'($urandom_range(0, 255)));
			end
			send_item(mbrtu_pkg::MODE_START, 8'($urandom_range(0, 255)));
			pick = $urandom_range(0, 9);
			flaw = (pick < 6) ? FLAW_NONE : (pick < 8) ? FLAW_FLIP : (pick < 9) ? FLAW_CUT
				: FLAW_TAIL;
			send_response(flaw);
		end
		quiet_gaps = 1'b0;
	endtask

	// Receiver side: stalls a random number of cycles before each transfer.
	initial begin
		int n;
		result_stall = 1'b0;
		forever begin
			n = quiet_gaps ? 0 : $urandom_range(0, 16);
			if (n > 0) begin
				@(negedge clk);
				result_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk);
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	always @(posedge clk) begin
		mbrtu_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (engine_out_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none,", $time,
					" got kind %0d payload %h status %0d last %0d",
					result.kind, result.payload, result.status, result.last);
			end else begin
				want = engine_out_q.pop_front();
				results_checked++;
				if (result !== want) begin
					errors++;
					$display("%0t: result mismatch:", $time,
						" expected kind %0d payload %h status %0d last %0d,",
						want.kind, want.payload, want.status, want.last,
						" got kind %0d payload %h status %0d last %0d",
						result.kind, result.payload, result.status, result.last);
				end
			end
		end
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("modbus_rtu_master_frame_engine_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = mbrtu_pkg::CFG_SLAVE_ADDRESS;
		cfg_data = 16'h0000;
		item_valid = 1'b0;
		item = '0;
		quiet_gaps = 1'b0;
		errors = 0;
		items_sent = 0;
		results_checked = 0;
		transactions = 0;
		settings_applied = 0;
		idle_cycles = 0;
		seen_status = '0;
		// Values after reset.
		m_slave = 8'd1;
		m_fsel = 1'b0;
		m_raddr = 16'd0;
		m_rcount = 7'd1;
		m_wvalue = 16'd0;
		rx_phase = mbrtu_pkg::PH_IDLE;
		rx_pos = 8'd0;
		rx_crc = mbrtu_pkg::CRC_INIT;
		rx_held = 8'd0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_count_limits();
		test_write_echo();
		test_random_traffic();
		settle();

		$display("Sent %0d items in %0d transactions", items_sent, transactions,
			" over %0d register settings; %0d results checked.",
			settings_applied, results_checked);
		$display("Distinct final status codes reached: %0d of 7.", $countones(seen_status));
		if (errors == 0) begin
			$display("modbus_rtu_master_frame_engine_tb: PASS");
		end else begin
			$display("modbus_rtu_master_frame_engine_tb: FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/mbrtu_pkg.sv
rtl/modbus_rtu_master_frame_engine.sv
tb/modbus_rtu_master_frame_engine_tb.sv
